// ===== hw/rtl/mqsb_pkg.sv =====
// Package for the multi-queue shared buffer: item payload types, result codes and
// the command group from controller to datapath. No dependencies.
package mqsb_pkg;

    localparam int WORD_W = 32;
    localparam int QNUM_W = 2;

    localparam logic KIND_ENQ = 1'b0;
    localparam logic KIND_DEQ = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;

    typedef struct packed {
        logic                     kind;
        logic [QNUM_W-1:0]        queue_number;
        logic signed [WORD_W-1:0] push_word;
    } req_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] pop_word;
        logic [1:0]               status;
    } rsp_t;

    typedef struct packed {
        logic accept;   // latch item and issue memory reads
        logic exec;     // update pointers, write memories, load result
    } ctl_cmd_t;

endpackage

// ===== hw/rtl/mqsb_if.sv =====
// Valid/ready channel carrying one payload item per handshake.
// Payload type is a parameter; used with types from mqsb_pkg.
interface mqsb_if #(parameter type data_t = logic);
    logic  valid;
    logic  ready;
    data_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/mqsb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mqsb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ===== hw/rtl/mqsb_ctrl.sv =====
// Controller for the multi-queue shared buffer: sequences accept and execute
// cycles and owns the result valid flag. Depends on mqsb_pkg.
module mqsb_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output mqsb_pkg::ctl_cmd_t  cmd
);
    import mqsb_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    assign in_ready   = (state_reg == S_IDLE);
    assign cmd.accept = (state_reg == S_IDLE) && in_valid;
    // execute only once the result register is free or being emptied
    assign cmd.exec   = (state_reg == S_EXEC) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (cmd.exec)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
endmodule

// ===== hw/rtl/mqsb_dp.sv =====
// Datapath for the multi-queue shared buffer: queue and free-list pointers,
// link and data memories, result register. Depends on mqsb_pkg and mqsb_ram.
module mqsb_dp #(
    parameter int SLOTS  = 16,
    parameter int QUEUES = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  mqsb_pkg::ctl_cmd_t cmd,
    input  mqsb_pkg::req_t     req_data,
    output mqsb_pkg::rsp_t     rsp_data
);
    import mqsb_pkg::*;

    localparam int SW  = $clog2(SLOTS + 1);     // slot code, null = SLOTS
    localparam int AW  = $clog2(SLOTS);
    localparam int QN  = (QUEUES < (1 << QNUM_W)) ? QUEUES : (1 << QNUM_W);
    localparam int QIW = (QN > 1) ? $clog2(QN) : 1;
    localparam logic [SW-1:0] NIL = SW'(SLOTS);

    logic [SW-1:0] head_reg [QN];
    logic [SW-1:0] head_next [QN];
    logic [SW-1:0] tail_reg [QN];
    logic [SW-1:0] tail_next [QN];
    logic [SW-1:0] free_head_reg;
    logic [SW-1:0] free_head_next;
    logic [SW-1:0] fill_reg;        // slots below this have been allocated at least once
    logic [SW-1:0] fill_next;

    logic                     kind_reg;
    logic [QIW-1:0]           qi_reg;
    logic                     qok_reg;
    logic signed [WORD_W-1:0] word_reg;
    logic signed [WORD_W-1:0] pop_word_reg;
    logic signed [WORD_W-1:0] pop_word_next;
    logic [1:0]               status_reg;
    logic [1:0]               status_next;

    logic [QIW-1:0] qi_in;
    logic           qok_in;
    logic [SW-1:0]  rd_slot;
    logic [SW-1:0]  head_q;
    logic [SW-1:0]  tail_q;
    logic [SW-1:0]  link_rd;
    logic [SW-1:0]  link_norm;
    logic [WORD_W-1:0] data_rd;
    logic           link_we;
    logic [AW-1:0]  link_waddr;
    logic [SW-1:0]  link_wdata;
    logic           data_we;

    assign qi_in  = QIW'(req_data.queue_number);
    assign qok_in = ({1'b0, req_data.queue_number} < (QNUM_W + 1)'(QN));

    // read address: free-list head for enqueue, queue head for dequeue
    always_comb
    begin
        if (req_data.kind == KIND_DEQ)
        begin
            rd_slot = qok_in ? head_reg[qi_in] : NIL;
        end
        else
        begin
            rd_slot = free_head_reg;
        end
    end

    mqsb_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .re    (cmd.accept),
        .raddr (rd_slot[AW-1:0]),
        .rdata (link_rd)
    );

    mqsb_ram #(.WIDTH(WORD_W), .DEPTH(SLOTS)) u_data_ram (
        .clk   (clk),
        .we    (data_we),
        .waddr (free_head_reg[AW-1:0]),
        .wdata (word_reg),
        .re    (cmd.accept),
        .raddr (rd_slot[AW-1:0]),
        .rdata (data_rd)
    );

    assign head_q    = head_reg[qi_reg];
    assign tail_q    = tail_reg[qi_reg];
    assign link_norm = (link_rd < NIL) ? link_rd : NIL;

    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        free_head_next = free_head_reg;
        fill_next      = fill_reg;
        link_we        = 1'b0;
        link_waddr     = '0;
        link_wdata     = '0;
        data_we        = 1'b0;
        pop_word_next  = pop_word_reg;
        status_next    = status_reg;
        if (cmd.exec)
        begin
            if (kind_reg == KIND_ENQ)
            begin
                pop_word_next = '0;
                if (!qok_reg || (free_head_reg == NIL))
                begin
                    status_next = ST_OVERFLOW;
                end
                else
                begin
                    status_next = ST_OK;
                    // untouched slots still chain to the next index
                    if (free_head_reg < fill_reg)
                    begin
                        free_head_next = link_norm;
                    end
                    else
                    begin
                        free_head_next = free_head_reg + SW'(1);
                    end
                    if (free_head_reg == fill_reg)
                    begin
                        fill_next = fill_reg + SW'(1);
                    end
                    if (head_q == NIL)
                    begin
                        head_next[qi_reg] = free_head_reg;
                    end
                    else
                    begin
                        link_we    = 1'b1;
                        link_waddr = tail_q[AW-1:0];
                        link_wdata = free_head_reg;
                    end
                    tail_next[qi_reg] = free_head_reg;
                    data_we           = 1'b1;
                end
            end
            else
            begin
                if (!qok_reg || (head_q == NIL))
                begin
                    pop_word_next = '1;
                    status_next   = ST_UNDERFLOW;
                end
                else
                begin
                    pop_word_next = data_rd;
                    status_next   = ST_OK;
                    // the tail's link is never stored: it ends the list
                    if ((head_q == tail_q) || (link_norm == NIL))
                    begin
                        head_next[qi_reg] = NIL;
                        tail_next[qi_reg] = NIL;
                    end
                    else
                    begin
                        head_next[qi_reg] = link_norm;
                    end
                    link_we        = 1'b1;
                    link_waddr     = head_q[AW-1:0];
                    link_wdata     = free_head_reg;
                    free_head_next = head_q;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < QN; i++)
            begin
                head_reg[i] <= NIL;
                tail_reg[i] <= NIL;
            end
            free_head_reg <= '0;
            fill_reg      <= '0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            free_head_reg <= free_head_next;
            fill_reg      <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            kind_reg <= req_data.kind;
            qi_reg   <= qi_in;
            qok_reg  <= qok_in;
            word_reg <= req_data.push_word;
        end
        pop_word_reg <= pop_word_next;
        status_reg   <= status_next;
    end

    assign rsp_data.pop_word = pop_word_reg;
    assign rsp_data.status   = status_reg;
endmodule

// ===== hw/rtl/multi_queue_shared_buffer_unit.sv =====
// Top level of the multi-queue shared buffer: several FIFO queues linked through
// one slot store. Depends on mqsb_pkg, mqsb_if, mqsb_ctrl and mqsb_dp.
//
//   channel  dir  payload                                   handshake
//   req      in   kind, queue_number, push_word (req_t)     valid/ready
//   rsp      out  pop_word, status (rsp_t)                  valid/ready
//
// Each item has an accept cycle and an execute cycle: in the accept cycle the link and
// data memories are read at the free-list head (enqueue) or the queue head (dequeue);
// in the execute cycle the pointers are updated, at most one link and one data word
// are written and the result register is loaded.
// Reset clears all queue pointers and the free list at once: a fill count stands
// in for the initial slot chain, so there is no clearing pass.
// A result waits in its register while a new item is accepted; the execute
// cycle holds only while that register is full and not being taken.
module multi_queue_shared_buffer_unit #(
    parameter int SLOTS  = 16,
    parameter int QUEUES = 4
) (
    input logic   clk,
    input logic   rst_n,
    mqsb_if.sink  req,
    mqsb_if.source rsp
);
    import mqsb_pkg::*;

    ctl_cmd_t cmd;
    req_t     req_data;
    rsp_t     rsp_data;

    // one item in flight; the controller sequences accept and execute
    mqsb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd)
    );

    assign req_data = req.data;

    // pointers, memories and result register
    mqsb_dp #(.SLOTS(SLOTS), .QUEUES(QUEUES)) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .req_data (req_data),
        .rsp_data (rsp_data)
    );

    assign rsp.data = rsp_data;
endmodule

// ===== verif/tb_multi_queue_shared_buffer_unit.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for multi_queue_shared_buffer_unit: directed table plus random
// enqueue/dequeue traffic, scored against a linked-list shadow of the slot store.
// Depends on mqsb_pkg, mqsb_if and the RTL of the unit.
module tb_multi_queue_shared_buffer_unit;

    import mqsb_pkg::*;

    localparam int SLOTS      = 16;
    localparam int QUEUES     = 4;
    localparam int PTR_W      = $clog2(SLOTS + 1);
    localparam int NIL        = SLOTS;          // null pointer code
    localparam int RAND_ITEMS = 1000;
    localparam int CHUNK      = 40;             // random items per traffic profile
    localparam int IDLE_LIMIT = 1000;           // cycles with no handshake at all

    typedef logic [PTR_W-1:0] slot_ptr_t;

    typedef struct {
        req_t item;
        bit   typed;        // want holds a hand-written expectation
        rsp_t want;
    } directed_row_t;

    logic clk;
    logic rst_n;

    mqsb_if #(.data_t(req_t)) req_ch ();
    mqsb_if #(.data_t(rsp_t)) rsp_ch ();

    multi_queue_shared_buffer_unit #(
        .SLOTS (SLOTS),
        .QUEUES(QUEUES)
    ) u_top (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch),
        .rsp  (rsp_ch)
    );

    // Shadow of the slot store: data, links, per-queue head/tail and the free list.
    logic [WORD_W-1:0] shadow_data [SLOTS];
    slot_ptr_t         shadow_link [SLOTS];
    slot_ptr_t         shadow_head [QUEUES];
    slot_ptr_t         shadow_tail [QUEUES];
    slot_ptr_t         shadow_free;

    rsp_t          pending_results[$];
    directed_row_t directed_rows[$];

    int  error_count;
    int  idle_cycles;
    int  enq_ok_count;
    int  deq_ok_count;
    int  overflow_count;
    int  underflow_count;
    bit  no_idle;           // set for stretches of back-to-back traffic on both sides
    bit  stimulus_done;

    // 20 ns clock
    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Bring the shadow to its reset state: every slot chained on the free list.
    task automatic reset_shadow();
        for (int i = 0; i < SLOTS; i++)
        begin
            shadow_data[i] = '0;
            shadow_link[i] = slot_ptr_t'(i + 1);   // last one becomes NIL
        end
        for (int q = 0; q < QUEUES; q++)
        begin
            shadow_head[q] = slot_ptr_t'(NIL);
            shadow_tail[q] = slot_ptr_t'(NIL);
        end
        shadow_free = '0;
    endtask

    // Apply one item to the shadow store and return the result it must produce.
    function automatic rsp_t predict_queue_op(req_t item);
        rsp_t      res;
        slot_ptr_t s;
        int        q;
        q = int'(item.queue_number);
        if (item.kind == KIND_ENQ)
        begin
            res.pop_word = '0;
            if (q >= QUEUES || shadow_free >= SLOTS)
            begin
                res.status = ST_OVERFLOW;
                return res;
            end
            // take the free-list head and link it behind the tail
            s = shadow_free;
            shadow_free = (shadow_link[s] < SLOTS) ? shadow_link[s] : slot_ptr_t'(NIL);
            if (shadow_head[q] >= SLOTS || shadow_tail[q] >= SLOTS)
                shadow_head[q] = s;
            else
                shadow_link[shadow_tail[q]] = s;
            shadow_link[s] = slot_ptr_t'(NIL);
            shadow_tail[q] = s;
            shadow_data[s] = item.push_word;
            res.status = ST_OK;
        end
        else
        begin
            if (q >= QUEUES || shadow_head[q] >= SLOTS)
            begin
                res.pop_word = '1;
                res.status   = ST_UNDERFLOW;
                return res;
            end
            // unlink the head slot and push it onto the front of the free list
            s = shadow_head[q];
            shadow_head[q] = (shadow_link[s] < SLOTS) ? shadow_link[s] : slot_ptr_t'(NIL);
            if (shadow_head[q] >= SLOTS)
                shadow_tail[q] = slot_ptr_t'(NIL);   // queue drained
            shadow_link[s] = shadow_free;
            shadow_free    = s;
            res.pop_word   = shadow_data[s];
            res.status     = ST_OK;
        end
        return res;
    endfunction

    function automatic int draw_wait();
        return no_idle ? 0 : int'($urandom_range(0, 15));
    endfunction

    function automatic logic [WORD_W-1:0] draw_word();
        case ($urandom_range(0, 15))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_row(logic kind, int q, logic [WORD_W-1:0] word, bit typed,
                           logic [WORD_W-1:0] pop, logic [1:0] st);
        directed_row_t row;
        row.item.kind         = kind;
        row.item.queue_number = QNUM_W'(q);
        row.item.push_word    = word;
        row.typed             = typed;
        row.want.pop_word     = pop;
        row.want.status       = st;
        directed_rows.push_back(row);
    endtask

    // Present one item after a gap, hold it until the handshake, then log its expectation.
    // Drive valid only once per time step: a gap of zero keeps it high into the next item.
    task automatic send_item(req_t item, bit typed, rsp_t want, int gap);
        rsp_t predicted;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= item;
        do
            @(posedge clk);
        while (!req_ch.ready);
        predicted = predict_queue_op(item);
        pending_results.push_back(typed ? want : predicted);
    endtask

    // Stimulus: reset, the directed table, then random traffic in profiles.
    initial
    begin
        req_t item;
        rsp_t none;
        int   enq_pct;
        int   focus_q;
        bit   focused;

        rst_n        <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.data  <= '0;
        none          = '0;
        stimulus_done = 1'b0;
        no_idle       = 1'b0;
        reset_shadow();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed table. Underflow on every empty queue, word extremes, a full store.
        for (int q = 0; q < QUEUES; q++)
            add_row(KIND_DEQ, q, 32'h1234_5678, 1'b1, 32'hFFFF_FFFF, ST_UNDERFLOW);
        add_row(KIND_ENQ, 0, 32'h7FFF_FFFF, 1'b1, 32'h0, ST_OK);
        add_row(KIND_ENQ, 0, 32'h8000_0000, 1'b1, 32'h0, ST_OK);
        add_row(KIND_DEQ, 0, 32'hFFFF_FFFF, 1'b1, 32'h7FFF_FFFF, ST_OK);
        for (int q = 1; q < QUEUES; q++)
            add_row(KIND_ENQ, q, $urandom, 1'b0, '0, ST_OK);
        // fill the remaining twelve slots across all queues
        for (int i = 0; i < SLOTS - QUEUES; i++)
            add_row(KIND_ENQ, i % QUEUES, draw_word(), 1'b0, '0, ST_OK);
        add_row(KIND_ENQ, 2, 32'hDEAD_BEEF, 1'b1, 32'h0, ST_OVERFLOW);
        add_row(KIND_DEQ, 0, 32'h0, 1'b1, 32'h8000_0000, ST_OK);
        add_row(KIND_ENQ, 3, 32'h0000_0001, 1'b0, '0, ST_OK);

        foreach (directed_rows[i])
            send_item(directed_rows[i].item, directed_rows[i].typed,
                      directed_rows[i].want, draw_wait());

        // Random part: each profile biases toward filling or draining, sometimes on one
        // queue only, so the store runs full and queues drain to empty over and over.
        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            if (n % CHUNK == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       enq_pct = 20;
                    1:       enq_pct = 50;
                    default: enq_pct = 80;
                endcase
                focused = ($urandom_range(0, 1) == 1);
                focus_q = $urandom_range(0, QUEUES - 1);
                no_idle = ($urandom_range(0, 3) == 0);
            end
            item.kind = ($urandom_range(1, 100) <= enq_pct) ? KIND_ENQ : KIND_DEQ;
            if (focused && $urandom_range(0, 3) != 0)
                item.queue_number = QNUM_W'(focus_q);
            else
                item.queue_number = QNUM_W'($urandom_range(0, QUEUES - 1));
            item.push_word = draw_word();
            send_item(item, 1'b0, none, draw_wait());
        end
        req_ch.valid  <= 1'b0;
        no_idle        = 1'b0;
        stimulus_done  = 1'b1;
    end

    // Result side: stall a random number of cycles, then hold ready until a result is taken.
    initial
    begin
        rsp_t want;
        int   wait_cycles;
        rsp_ch.ready    <= 1'b0;
        error_count     = 0;
        enq_ok_count    = 0;
        deq_ok_count    = 0;
        overflow_count  = 0;
        underflow_count = 0;
        @(posedge rst_n);
        forever
        begin
            wait_cycles = draw_wait();
            if (wait_cycles > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (wait_cycles) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_ch.valid);
            // values read here are the ones present at the edge
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result pop_word=%0d status=%0d", $time,
                         rsp_ch.data.pop_word, rsp_ch.data.status);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp_ch.data.pop_word !== want.pop_word)
                begin
                    $display("%0t: pop_word mismatch expected %0d actual %0d", $time,
                             want.pop_word, rsp_ch.data.pop_word);
                    error_count++;
                end
                if (rsp_ch.data.status !== want.status)
                begin
                    $display("%0t: status mismatch expected %0d actual %0d", $time,
                             want.status, rsp_ch.data.status);
                    error_count++;
                end
                case (want.status)
                    ST_OVERFLOW:  overflow_count++;
                    ST_UNDERFLOW: underflow_count++;
                    default:
                    begin
                        if (want.pop_word == '0 && rsp_ch.data.status === ST_OK)
                            enq_ok_count++;
                        else
                            deq_ok_count++;
                    end
                endcase
            end
        end
    end

    // Watchdog: end the run if neither channel moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: timeout, %0d results still outstanding", $time,
                     pending_results.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // End of run: drain, wait for any stray results to show up, then report.
    initial
    begin
        wait (stimulus_done);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        $display("Run covered %0d directed and %0d random items on %0d queues of %0d slots.",
                 directed_rows.size(), RAND_ITEMS, QUEUES, SLOTS);
        $display("Outcomes: %0d enqueues (or zero-word pops), %0d pops,",
                 enq_ok_count, deq_ok_count);
        $display("          %0d overflows, %0d underflows.",
                 overflow_count, underflow_count);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/mqsb_pkg.sv
hw/rtl/mqsb_if.sv
hw/rtl/mqsb_ram.sv
hw/rtl/mqsb_ctrl.sv
hw/rtl/mqsb_dp.sv
hw/rtl/multi_queue_shared_buffer_unit.sv
verif/tb_multi_queue_shared_buffer_unit.sv
